/* hw/rtl/bdlp_pkg.sv */
// Shared constants and types for the button debouncer with long-press detection.
`default_nettype none

package bdlp_pkg;

  // Number of buttons sampled per transfer (up, down, select)
  localparam int NUM_BUTTONS = 3;

  // Default timestamp width
  localparam int TIME_BITS_DEF = 32;

  // Configuration register width and reset values
  localparam int          CFG_W          = 16;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_t;

  // Timing settings handed to every button
  typedef struct packed {
    logic [CFG_W-1:0] settle_ms;
    logic [CFG_W-1:0] long_hold_ms;
  } cfg_t;

  // Event flags of one button for one sample
  typedef struct packed {
    logic short_f;
    logic long_f;
  } btn_flags_t;

endpackage : bdlp_pkg

`default_nettype wire

/* hw/rtl/bdlp_button.sv */
// Debounce and press-length tracking for a single button.
`default_nettype none

module bdlp_button
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 level,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire cfg_t                 cfg,
  output btn_flags_t                flags
);

  logic                 last_level_r;
  logic [TIME_BITS-1:0] last_change_r;
  logic [TIME_BITS-1:0] press_start_r;
  logic                 press_active_r;
  logic                 long_reported_r;

  logic                 changed;
  logic [TIME_BITS-1:0] since_change;
  logic                 steady;
  logic                 starting;
  logic [TIME_BITS-1:0] held;
  logic                 lr_eff;
  logic                 fire_long;

  // Level steady for longer than the debounce time (a change restarts it)
  always_comb begin
    changed      = (level != last_level_r);
    since_change = now - last_change_r;
    steady       = !changed && (since_change > TIME_BITS'(cfg.settle_ms));
  end

  // Press length; a press that starts now has been held for zero ms
  always_comb begin
    starting  = !press_active_r;
    held      = starting ? '0 : (now - press_start_r);
    lr_eff    = starting ? 1'b0 : long_reported_r;
    fire_long = !lr_eff && (held >= TIME_BITS'(cfg.long_hold_ms));
  end

  // Flags for this sample
  always_comb begin
    flags.long_f  = step && steady && !level && fire_long;
    flags.short_f = step && steady && level && press_active_r && !long_reported_r;
  end

  // Per-button state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r    <= 1'b1;
      last_change_r   <= '0;
      press_active_r  <= 1'b0;
      long_reported_r <= 1'b0;
    end else if (step) begin
      last_level_r <= level;
      if (changed) begin
        last_change_r <= now;
      end
      if (steady) begin
        if (!level) begin
          press_active_r  <= 1'b1;
          long_reported_r <= lr_eff | fire_long;
        end else begin
          press_active_r  <= 1'b0;
          long_reported_r <= 1'b0;
        end
      end
    end
  end

  // Press start time, only read while a press is active
  always_ff @(posedge clk) begin
    if (step && steady && !level && starting) begin
      press_start_r <= now;
    end
  end

endmodule : bdlp_button

`default_nettype wire

/* hw/rtl/button_debounce_long_press.sv */
// Top level of the three-button debouncer with short and long press events.
// Each input transfer carries one sample of the active-low up, down and select
// pins plus a wrapping millisecond timestamp, and yields exactly one result
// transfer with a short and a long flag per button. A sample is taken every
// cycle while the result side keeps taking transfers; it sits in the input
// register, where every button does its debounce and press-length
// subtract/compare in parallel, and is then held in the result register.
// Debounce and long-press times are written through the cfg port; the user must
// write them only while the block is idle, and the block does not enforce this.
`default_nettype none

module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TIME_BITS-1:0] in_now_ms,
  input  wire logic                 in_up_level,
  input  wire logic                 in_down_level,
  input  wire logic                 in_select_level,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_short_up,
  output logic                      out_short_down,
  output logic                      out_short_select,
  output logic                      out_long_up,
  output logic                      out_long_down,
  output logic                      out_long_select,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t                   cfg_r;
  logic                   s1_valid_r;
  logic [TIME_BITS-1:0]   s1_now_r;
  logic [NUM_BUTTONS-1:0] s1_level_r;
  logic                   s1_go;
  logic                   out_valid_r;
  logic [NUM_BUTTONS-1:0] short_r;
  logic [NUM_BUTTONS-1:0] long_r;
  btn_flags_t             flags [NUM_BUTTONS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms    <= DEBOUNCE_RST;
      cfg_r.long_hold_ms <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:   cfg_r.settle_ms    <= cfg_wdata;
        CFG_LONG_PRESS: cfg_r.long_hold_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: sample moves on when the result register is free or draining
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now_r   <= in_now_ms;
      s1_level_r <= {in_select_level, in_down_level, in_up_level};
    end
  end

  // Per-button trackers
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    bdlp_button #(
      .TIME_BITS (TIME_BITS)
    ) u_btn (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (s1_go),
      .level (s1_level_r[b]),
      .now   (s1_now_r),
      .cfg   (cfg_r),
      .flags (flags[b])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        short_r[b] <= flags[b].short_f;
        long_r[b]  <= flags[b].long_f;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_short_up     = short_r[0];
  assign out_short_down   = short_r[1];
  assign out_short_select = short_r[2];
  assign out_long_up      = long_r[0];
  assign out_long_down    = long_r[1];
  assign out_long_select  = long_r[2];

endmodule : button_debounce_long_press

`default_nettype wire

/* hw/rtl/bdlp_checker.sv */
// Port-level checks for the button debouncer, bound to the top level.
`default_nettype none

module bdlp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_short_up,
  input wire logic out_short_down,
  input wire logic out_short_select,
  input wire logic out_long_up,
  input wire logic out_long_down,
  input wire logic out_long_select
);

  // Result held steady while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_short_up) &&
      $stable(out_short_down) && $stable(out_short_select) &&
      $stable(out_long_up) && $stable(out_long_down) && $stable(out_long_select))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A transfer never flags both a short and a long press on one button
  a_short_long_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_short_up && out_long_up) ||
      (out_short_down && out_long_down) ||
      (out_short_select && out_long_select)))
    else $error("short and long press on the same button");

  // Input stalls only when a result is waiting and not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule : bdlp_checker

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_short_up     (out_short_up),
  .out_short_down   (out_short_down),
  .out_short_select (out_short_select),
  .out_long_up      (out_long_up),
  .out_long_down    (out_long_down),
  .out_long_select  (out_long_select)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the three-button debouncer with short and long press events.
module testbench;
  import bdlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;   // cycles with no transfer before giving up
  localparam int HOLD_CYCLES = 400;    // long result-side hold-off
  localparam int REPORT_CAP  = 100;

  // One sample of the pins; bit 0 up, bit 1 down, bit 2 select
  typedef struct packed {
    logic [31:0]            now;
    logic [NUM_BUTTONS-1:0] lvl;
  } pin_sample_t;

  // Expected event flags of one result
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] short_f;
    logic [NUM_BUTTONS-1:0] long_f;
  } press_events_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [31:0] in_now_ms;
  logic in_up_level;
  logic in_down_level;
  logic in_select_level;
  logic out_valid;
  logic out_ready;
  logic out_short_up;
  logic out_short_down;
  logic out_short_select;
  logic out_long_up;
  logic out_long_down;
  logic out_long_select;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  button_debounce_long_press dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_now_ms       (in_now_ms),
    .in_up_level     (in_up_level),
    .in_down_level   (in_down_level),
    .in_select_level (in_select_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_short_up    (out_short_up),
    .out_short_down  (out_short_down),
    .out_short_select(out_short_select),
    .out_long_up     (out_long_up),
    .out_long_down   (out_long_down),
    .out_long_select (out_long_select),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  pin_sample_t   samples_q[$];   // samples waiting to be sent
  press_events_t events_q[$];    // predicted results, oldest first

  int errors;
  int results_seen;
  int quiet_cycles;
  int tx_wait;
  int rx_wait;
  int hold_left;
  bit hold_done;
  logic in_acc;
  logic out_acc;
  logic [15:0] cyc;
  string btn_name[NUM_BUTTONS] = '{"up", "down", "select"};

  // Predictor state
  logic [CFG_W-1:0] deb_ms;
  logic [CFG_W-1:0] hold_ms;
  logic             prev_lvl[NUM_BUTTONS];
  logic [31:0]      chg_at[NUM_BUTTONS];
  logic [31:0]      press_at[NUM_BUTTONS];
  logic             pressing[NUM_BUTTONS];
  logic             long_done[NUM_BUTTONS];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_tracker();
    deb_ms  = DEBOUNCE_RST;
    hold_ms = LONG_PRESS_RST;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      prev_lvl[b]  = 1'b1;
      chg_at[b]    = '0;
      press_at[b]  = '0;
      pressing[b]  = 1'b0;
      long_done[b] = 1'b0;
    end
  endfunction

  // Debounce every pin, then turn steady levels into press events
  function automatic press_events_t debounce_step(pin_sample_t s);
    press_events_t ev;
    logic [31:0] steady;
    logic [31:0] held;
    ev = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (s.lvl[b] != prev_lvl[b]) chg_at[b] = s.now;
      steady = s.now - chg_at[b];
      if (steady > {16'd0, deb_ms}) begin
        if (!s.lvl[b]) begin
          if (!pressing[b]) begin
            pressing[b]  = 1'b1;
            press_at[b]  = s.now;
            long_done[b] = 1'b0;
          end
          held = s.now - press_at[b];
          if (!long_done[b] && held >= {16'd0, hold_ms}) begin
            ev.long_f[b] = 1'b1;
            long_done[b] = 1'b1;
          end
        end else begin
          if (pressing[b] && !long_done[b]) ev.short_f[b] = 1'b1;
          pressing[b]  = 1'b0;
          press_at[b]  = '0;
          long_done[b] = 1'b0;
        end
      end
      prev_lvl[b] = s.lvl[b];
    end
    return ev;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    else if (r < 95) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Transfer tracking, prediction and result checking
  always @(posedge clk) begin
    press_events_t exp_ev;
    press_events_t got_ev;
    cyc     <= cyc + 16'd1;
    in_acc  <= rst_n && in_valid && in_ready;
    out_acc <= rst_n && out_valid && out_ready;
    if (!rst_n) begin
      clear_tracker();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DEBOUNCE:   deb_ms  = cfg_wdata;
          CFG_LONG_PRESS: hold_ms = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        events_q.push_back(debounce_step({in_now_ms, in_select_level, in_down_level,
                                          in_up_level}));
      if (out_valid && out_ready) begin
        results_seen++;
        got_ev.short_f = {out_short_select, out_short_down, out_short_up};
        got_ev.long_f  = {out_long_select, out_long_down, out_long_up};
        if (events_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, got short %b long %b",
                     $time, got_ev.short_f, got_ev.long_f);
        end else begin
          exp_ev = events_q.pop_front();
          for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (got_ev.short_f[b] !== exp_ev.short_f[b]) begin
              errors++;
              if (errors <= REPORT_CAP)
                $display("%0t: short_%s expected %b, got %b", $time, btn_name[b],
                         exp_ev.short_f[b], got_ev.short_f[b]);
            end
            if (got_ev.long_f[b] !== exp_ev.long_f[b]) begin
              errors++;
              if (errors <= REPORT_CAP)
                $display("%0t: long_%s expected %b, got %b", $time, btn_name[b],
                         exp_ev.long_f[b], got_ev.long_f[b]);
            end
          end
        end
      end
    end
  end

  // Sample driver: holds a sample until its transfer, then maybe idles
  always @(negedge clk) begin
    pin_sample_t s;
    if (!in_valid || in_acc) begin
      if (in_acc) tx_wait = idle_len(cyc[9:7] == 3'd1);
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (samples_q.size() > 0) begin
        s = samples_q.pop_front();
        in_valid        <= 1'b1;
        in_now_ms       <= s.now;
        in_up_level     <= s.lvl[0];
        in_down_level   <= s.lvl[1];
        in_select_level <= s.lvl[2];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls plus one long hold-off while samples keep coming
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen > 200 && samples_q.size() > 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_wait == 0 && out_acc) rx_wait = idle_len(cyc[8:6] == 3'd6);
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void push_sample(logic [31:0] now, logic [NUM_BUTTONS-1:0] lvl);
    samples_q.push_back({now, lvl});
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every sample is sent and every result has come back;
  // checked at the rising edge, where the driver's outputs have settled
  task automatic drain();
    while (samples_q.size() != 0 || in_valid || events_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One setting: program both timers, then random button activity on a time cursor
  task automatic run_setting(logic [15:0] deb, logic [15:0] lng, int count, bit near_wrap);
    logic [31:0] t;
    logic [NUM_BUTTONS-1:0] lv;
    int scale;
    int r;
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG_PRESS, lng);
    scale = ((deb > lng) ? int'(deb) : int'(lng)) / 4 + 2;
    t = near_wrap ? 32'hFFFF_FFFF - $urandom_range(0, 4 * scale) : $urandom();
    lv = '1;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // noise: arbitrary time and pins
        push_sample($urandom(), NUM_BUTTONS'($urandom()));
      end else begin
        if (r < 10) t += $urandom();
        else t += $urandom_range(0, scale);
        for (int b = 0; b < NUM_BUTTONS; b++)
          if ($urandom_range(0, 99) < 12) lv[b] = ~lv[b];
        push_sample(t, lv);
      end
    end
    drain();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_now_ms       = '0;
    in_up_level     = 1'b1;
    in_down_level   = 1'b1;
    in_select_level = 1'b1;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_DEBOUNCE;
    cfg_wdata       = '0;
    cyc             = '0;
    in_acc          = 1'b0;
    out_acc         = 1'b0;
    errors          = 0;
    results_seen    = 0;
    quiet_cycles    = 0;
    tx_wait         = 0;
    rx_wait         = 0;
    hold_left       = 0;
    hold_done       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset timers: debounce boundary, short and long presses, no short after long
    push_sample(32'd0, 3'b111);
    push_sample(32'd0, 3'b000);
    push_sample(32'd50, 3'b000);
    push_sample(32'd51, 3'b000);
    push_sample(32'd100, 3'b010);
    push_sample(32'd151, 3'b010);
    push_sample(32'd1050, 3'b010);
    push_sample(32'd1051, 3'b010);
    push_sample(32'd1052, 3'b110);
    push_sample(32'd1103, 3'b111);
    push_sample(32'd1154, 3'b111);
    // timestamp wrap across a press of down
    push_sample(32'hFFFF_FFF0, 3'b101);
    push_sample(32'h0000_0023, 3'b101);
    push_sample(32'hFFFF_FFFF, 3'b111);
    push_sample(32'h0000_0033, 3'b111);
    drain();

    // Zero debounce and zero long-press time
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG_PRESS, 16'd0);
    push_sample(32'h8000_0000, 3'b110);
    push_sample(32'h8000_0000, 3'b110);
    push_sample(32'h8000_0001, 3'b110);
    push_sample(32'h8000_0002, 3'b101);
    push_sample(32'h8000_0003, 3'b101);
    push_sample(32'h7FFF_FFFF, 3'b011);
    push_sample(32'h7FFF_FFFF, 3'b011);
    drain();

    // Random activity under several timer settings, extremes first
    run_setting(16'd0, 16'd0, 118, 1'b0);
    run_setting(16'hFFFF, 16'hFFFF, 118, 1'b1);
    run_setting(16'd0, 16'hFFFF, 118, 1'b0);
    run_setting(16'hFFFF, 16'd0, 118, 1'b1);
    run_setting(16'd20, 16'd300, 118, 1'b0);
    run_setting(16'($urandom_range(0, 100)), 16'($urandom_range(0, 600)), 118, 1'b1);
    run_setting(16'd3, 16'd10, 118, 1'b0);
    run_setting(DEBOUNCE_RST, LONG_PRESS_RST, 118, 1'b1);

    repeat (8) @(negedge clk);
    if (events_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected, got none", $time, events_q.size());
    end
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* button_debounce_long_press.f */
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_button.sv
hw/rtl/button_debounce_long_press.sv
hw/rtl/bdlp_checker.sv
bench/testbench.sv
